FILE: src/gau_pkg.sv
// Shared types and constants of the GELU activation unit.
// Holds the fixed-point formats, the Q2.30 coefficients and the per-item sideband.
// No dependencies; every other file imports this package.
package gau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  // Alignment of |x| to Q.16.
  localparam int UP_SHIFT  = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
  localparam int DN_SHIFT  = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
  localparam int AX_RAW_W  = DATA_WIDTH + UP_SHIFT;

  // |x| and |z| clamp at 16.0 in Q.16.
  localparam int AX_W      = 21;
  localparam int CMP_W     = (AX_RAW_W > AX_W) ? AX_RAW_W : AX_W;
  localparam logic [AX_W-1:0] ZCLAMP = {1'b1, 20'd0};

  // Intermediate widths of the argument path.
  localparam int SQ_W      = 25;
  localparam int CUBE_W    = 29;
  localparam int ALPHA_W   = 24;
  localparam int INNER_W   = 25;
  localparam int ZB_W      = 26;
  localparam int ZQ_W      = 21;
  localparam int T_W       = 35;
  localparam int N_W       = 5;
  localparam int U_W       = 30;
  localparam int ACC_W     = 31;
  localparam int D_W       = 32;
  localparam int GATE_W    = 17;

  localparam int TAYLOR_TERMS = 6;
  localparam int DIV_STEPS    = GATE_W;

  // Coefficients in Q2.30, rounded to nearest.
  localparam logic [ACC_W-1:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [25:0]      ALPHA_Q30 = 26'd48012366;
  localparam logic [30:0]      BETA2_Q30 = 31'd1713444046;
  localparam logic [30:0]      QUICK_Q30 = 31'd1827508584;
  localparam logic [30:0]      LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0]      LN2_Q30   = 30'd744261118;

  localparam logic [GATE_W-1:0] GATE_ONE = 17'h1_0000;

  // Output arithmetic widths.
  localparam int P_W = DATA_WIDTH + GATE_W + 1;
  localparam int Q_W = P_W + 1 - 16;

  typedef enum logic {
    MODE_TANH_GELU  = 1'b0,
    MODE_QUICK_GELU = 1'b1
  } func_mode_t;

  typedef struct packed {
    logic                         valid;
    logic                         last;
    logic                         neg;
    logic signed [DATA_WIDTH-1:0] x;
    logic [N_W-1:0]               n;
  } side_t;

  // floor((2^32 - 1) / k): the quotient estimate is at most one below the true value.
  function automatic logic [31:0] taylor_recip(input logic [2:0] k);
    logic [31:0] r;
    unique case (k)
      3'd1:    r = 32'hFFFF_FFFF;
      3'd2:    r = 32'h7FFF_FFFF;
      3'd3:    r = 32'h5555_5555;
      3'd4:    r = 32'h3FFF_FFFF;
      3'd5:    r = 32'h3333_3333;
      3'd6:    r = 32'h2AAA_AAAA;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

FILE: src/gau_intf.sv
// Stream interfaces of the GELU activation unit: samples in, results out.
// Depends on gau_pkg for the data width.
interface gau_sample_if import gau_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_in;
  logic                         last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface gau_result_if import gau_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_out;
  logic                         last_out;

  modport source (output valid, output result_out, output last_out, input ready);
  modport sink   (input valid, input result_out, input last_out, output ready);
endinterface

FILE: src/gau_taylor_step.sv
// One Horner step of the exp(-u) polynomial: acc = 1 - (u * acc) / k, three stages.
// Depends on gau_pkg; division by the small constant k uses a reciprocal and one correction.
module gau_taylor_step import gau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic [2:0]       k,
  input  logic [U_W-1:0]   u_in,
  input  logic [ACC_W-1:0] acc_in,
  input  side_t            side_in,
  output logic [U_W-1:0]   u_out,
  output logic [ACC_W-1:0] acc_out,
  output side_t            side_out
);

  logic [U_W+ACC_W-1:0] prod_a;
  logic [U_W+31:0]      prod_b;
  logic [31:0]          recip;
  logic [32:0]          kq;
  logic [32:0]          rem;
  logic [U_W-1:0]       q_fix;

  logic [U_W-1:0] m_a, m_b, q_b;
  logic [U_W-1:0] u_a, u_b;
  side_t          side_a, side_b;

  assign recip  = taylor_recip(k);
  assign prod_a = (U_W+ACC_W)'(u_in) * (U_W+ACC_W)'(acc_in);
  assign prod_b = (U_W+32)'(m_a) * (U_W+32)'(recip);
  assign kq     = 33'(q_b) * 33'(k);
  assign rem    = 33'(m_b) - kq;
  assign q_fix  = (rem >= 33'(k)) ? U_W'(q_b + 1'b1) : q_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a.valid   <= 1'b0;
      side_b.valid   <= 1'b0;
      side_out.valid <= 1'b0;
    end else if (ce) begin
      m_a      <= prod_a[30 +: U_W];
      u_a      <= u_in;
      side_a   <= side_in;
      q_b      <= prod_b[32 +: U_W];
      m_b      <= m_a;
      u_b      <= u_a;
      side_b   <= side_a;
      acc_out  <= Q30_ONE - ACC_W'(q_fix);
      u_out    <= u_b;
      side_out <= side_b;
    end
  end

endmodule

FILE: src/gau_gate_div.sv
// Pipelined restoring divider for the gate: g = (2^46 + d/2) / d, one quotient bit a stage.
// Depends on gau_pkg; d lies in [2^30, 2^31], so the quotient fits in GATE_W bits.
module gau_gate_div import gau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic [D_W-1:0]    d_in,
  input  side_t             side_in,
  output logic [GATE_W-1:0] gate_out,
  output side_t             side_out
);

  logic [D_W-1:0]    rem_q  [DIV_STEPS];
  logic [D_W-1:0]    dvs_q  [DIV_STEPS];
  logic [GATE_W-1:0] quo_q  [DIV_STEPS];
  side_t             side_q [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [D_W-1:0]    rem_p;
    logic [D_W-1:0]    dvs_p;
    logic [GATE_W-1:0] quo_p;
    side_t             side_p;
    logic [D_W:0]      trial;
    logic              take;

    if (i == 0) begin : g_first
      // The numerator bits above the quotient range form the first partial remainder.
      assign rem_p  = {2'b00, 1'b1, 15'd0, d_in[31:18]};
      assign dvs_p  = d_in;
      assign quo_p  = '0;
      assign side_p = side_in;
    end else begin : g_next
      assign rem_p  = rem_q[i-1];
      assign dvs_p  = dvs_q[i-1];
      assign quo_p  = quo_q[i-1];
      assign side_p = side_q[i-1];
    end

    // The low numerator bits equal d[17:1], because they come from the rounding term d/2.
    assign trial = {rem_p, dvs_p[17-i]};
    assign take  = (trial >= {1'b0, dvs_p});

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[i].valid <= 1'b0;
      end else if (ce) begin
        rem_q[i]  <= take ? D_W'(trial - {1'b0, dvs_p}) : trial[D_W-1:0];
        dvs_q[i]  <= dvs_p;
        quo_q[i]  <= {quo_p[GATE_W-2:0], take};
        side_q[i] <= side_p;
      end
    end
  end

  assign gate_out = quo_q[DIV_STEPS-1];
  assign side_out = side_q[DIV_STEPS-1];

endmodule

FILE: src/gelu_activation_unit_top.sv
// Top level of the GELU activation unit: tanh GELU or quick GELU on signed Q4.12 samples.
// Depends on gau_pkg, gau_intf, gau_taylor_step and gau_gate_div.
//
//   Channel    Dir  Handshake      Payload
//   sample_ch  in   valid / ready  sample_in (16, signed), last_in
//   result_ch  out  valid / ready  result_out (16, signed), last_out
//   cfg        in   cfg_we         cfg_wdata: function_mode
//
// One sample is accepted every cycle while the output buffer is not full.
// The pipeline has 46 register stages: seven for the argument, six three-stage polynomial
// steps, the divisor, a 17-stage gate divider and three for the output multiply and rounding.
// A two-entry output buffer takes the pipeline's results; the pipeline stalls as a whole
// only while that buffer is full, so sample_ch.ready does not depend on result_ch.ready.
// Reset is synchronous and clears the valid bits, the buffer and function_mode.
module gelu_activation_unit_top import gau_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  gau_sample_if.sink    sample_ch,
  gau_result_if.source  result_ch
);

  func_mode_t function_mode;
  logic       ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_mode <= MODE_TANH_GELU;
    end else if (cfg_we) begin
      function_mode <= func_mode_t'(cfg_wdata);
    end
  end

  // Stage 1: magnitude aligned to Q.16 and clamped.
  logic [DATA_WIDTH-1:0] abs_in;
  logic [CMP_W-1:0]      ax_wide;
  logic [AX_W-1:0]       ax_in;
  side_t                 side_in;

  assign abs_in  = sample_ch.sample_in[DATA_WIDTH-1] ?
                   DATA_WIDTH'(~sample_ch.sample_in + 1'b1) : sample_ch.sample_in;
  assign ax_wide = (CMP_W'(abs_in) << UP_SHIFT) >> DN_SHIFT;
  assign ax_in   = (ax_wide > CMP_W'(ZCLAMP)) ? ZCLAMP : ax_wide[AX_W-1:0];

  always_comb begin
    side_in.valid = sample_ch.valid;
    side_in.last  = sample_ch.last_in;
    side_in.neg   = sample_ch.sample_in[DATA_WIDTH-1];
    side_in.x     = sample_ch.sample_in;
    side_in.n     = '0;
  end

  side_t           s1, s2, s3, s4, s5, s6, s7;
  side_t           s6_next;
  func_mode_t      mode1, mode2, mode3, mode4;
  logic [AX_W-1:0] ax1, ax2, ax3;
  logic [SQ_W-1:0] sq2;
  logic [ZQ_W-1:0] zq2, zq3, zq4;
  logic [CUBE_W-1:0]  cube3;
  logic [INNER_W-1:0] inner4;
  logic [AX_W-1:0]    z5;
  logic [U_W-1:0]     f6;
  logic [U_W-1:0]     u7;

  logic [2*AX_W-1:0]         sq_full;
  logic [AX_W+30:0]          zq_full;
  logic [SQ_W+AX_W-1:0]      cube_full;
  logic [CUBE_W+25:0]        alpha_full;
  logic [INNER_W+30:0]       zb_full;
  logic [ZB_W-1:0]           z_sel;
  logic [AX_W+30:0]          t_full;
  logic [T_W-1:0]            t_val;
  logic [2*U_W-1:0]          u_full;

  assign sq_full    = (2*AX_W)'(ax1) * (2*AX_W)'(ax1);
  assign zq_full    = (AX_W+31)'(ax1) * (AX_W+31)'(QUICK_Q30);
  assign cube_full  = (SQ_W+AX_W)'(sq2) * (SQ_W+AX_W)'(ax2);
  assign alpha_full = (CUBE_W+26)'(cube3) * (CUBE_W+26)'(ALPHA_Q30);
  assign zb_full    = (INNER_W+31)'(inner4) * (INNER_W+31)'(BETA2_Q30);
  assign z_sel      = (mode4 == MODE_QUICK_GELU) ? ZB_W'(zq4) : zb_full[30 +: ZB_W];
  assign t_full     = (AX_W+31)'(z5) * (AX_W+31)'(LOG2E_Q30);
  assign t_val      = t_full[16 +: T_W];
  assign u_full     = (2*U_W)'(f6) * (2*U_W)'(LN2_Q30);

  always_comb begin
    s6_next   = s5;
    s6_next.n = t_val[T_W-1:U_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      s5.valid <= 1'b0;
      s6.valid <= 1'b0;
      s7.valid <= 1'b0;
    end else if (ce) begin
      s1     <= side_in;
      mode1  <= function_mode;
      ax1    <= ax_in;

      s2     <= s1;
      mode2  <= mode1;
      ax2    <= ax1;
      sq2    <= sq_full[16 +: SQ_W];
      zq2    <= zq_full[30 +: ZQ_W];

      s3     <= s2;
      mode3  <= mode2;
      ax3    <= ax2;
      zq3    <= zq2;
      cube3  <= cube_full[16 +: CUBE_W];

      s4     <= s3;
      mode4  <= mode3;
      zq4    <= zq3;
      inner4 <= INNER_W'(ax3) + INNER_W'(alpha_full[30 +: ALPHA_W]);

      s5     <= s4;
      z5     <= (z_sel > ZB_W'(ZCLAMP)) ? ZCLAMP : z_sel[AX_W-1:0];

      s6     <= s6_next;
      f6     <= t_val[U_W-1:0];

      s7     <= s6;
      u7     <= u_full[U_W +: U_W];
    end
  end

  // Degree-6 polynomial for exp(-u), evaluated by Horner steps from the highest term.
  logic [U_W-1:0]   tu   [TAYLOR_TERMS+1];
  logic [ACC_W-1:0] tacc [TAYLOR_TERMS+1];
  side_t            tside[TAYLOR_TERMS+1];

  assign tu[0]    = u7;
  assign tacc[0]  = Q30_ONE;
  assign tside[0] = s7;

  for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_taylor
    gau_taylor_step u_step (
      .clk      (clk),
      .rst      (rst),
      .ce       (ce),
      .k        (3'(TAYLOR_TERMS - j)),
      .u_in     (tu[j]),
      .acc_in   (tacc[j]),
      .side_in  (tside[j]),
      .u_out    (tu[j+1]),
      .acc_out  (tacc[j+1]),
      .side_out (tside[j+1])
    );
  end

  // Divisor of the gate: 1 + exp(-|z|) in Q2.30.
  side_t          sd;
  logic [D_W-1:0] dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd.valid <= 1'b0;
    end else if (ce) begin
      sd <= tside[TAYLOR_TERMS];
      dd <= D_W'(Q30_ONE) + D_W'(tacc[TAYLOR_TERMS] >> tside[TAYLOR_TERMS].n);
    end
  end

  logic [GATE_W-1:0] gate_div;
  side_t             sdiv;

  gau_gate_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .d_in     (dd),
    .side_in  (sd),
    .gate_out (gate_div),
    .side_out (sdiv)
  );

  // Gate of a negative sample, multiply, round half up and saturate.
  side_t                        sg, sp, sr;
  logic [GATE_W-1:0]            gs;
  logic signed [P_W-1:0]        prod_p;
  logic signed [DATA_WIDTH-1:0] res_r;
  logic signed [P_W-1:0]        prod_full;
  logic signed [P_W:0]          rsum;
  logic signed [Q_W-1:0]        qv;
  logic signed [DATA_WIDTH-1:0] res_sat;

  localparam logic signed [Q_W-1:0] RES_MAX = Q_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] RES_MIN = Q_W'(-(64'sd1 <<< (DATA_WIDTH - 1)));

  assign prod_full = P_W'(sg.x) * P_W'($signed({1'b0, gs}));
  assign rsum      = (P_W+1)'(prod_p) + (P_W+1)'(32768);
  assign qv        = rsum[P_W:16];

  always_comb begin
    if (qv > RES_MAX) begin
      res_sat = RES_MAX[DATA_WIDTH-1:0];
    end else if (qv < RES_MIN) begin
      res_sat = RES_MIN[DATA_WIDTH-1:0];
    end else begin
      res_sat = qv[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sg.valid <= 1'b0;
      sp.valid <= 1'b0;
      sr.valid <= 1'b0;
    end else if (ce) begin
      sg     <= sdiv;
      gs     <= sdiv.neg ? GATE_W'(GATE_ONE - gate_div) : gate_div;
      sp     <= sg;
      prod_p <= prod_full;
      sr     <= sp;
      res_r  <= res_sat;
    end
  end

  // Two-entry output buffer; slot 0 drives the result channel.
  logic [1:0]                   buf_count, buf_count_next;
  logic signed [DATA_WIDTH-1:0] buf_res0, buf_res1;
  logic                         buf_last0, buf_last1;
  logic                         push, pop;

  assign ce   = (buf_count != 2'd2);
  assign push = ce && sr.valid;
  assign pop  = result_ch.valid && result_ch.ready;

  assign sample_ch.ready      = ce;
  assign result_ch.valid      = (buf_count != 2'd0);
  assign result_ch.result_out = buf_res0;
  assign result_ch.last_out   = buf_last0;

  always_comb begin
    buf_count_next = buf_count;
    if (push && !pop) begin
      buf_count_next = buf_count + 2'd1;
    end else if (pop && !push) begin
      buf_count_next = buf_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 2'd0;
    end else begin
      buf_count <= buf_count_next;
      if (buf_count == 2'd2) begin
        if (pop) begin
          buf_res0  <= buf_res1;
          buf_last0 <= buf_last1;
        end
      end else if (push) begin
        if (buf_count == 2'd0 || pop) begin
          buf_res0  <= res_r;
          buf_last0 <= sr.last;
        end else begin
          buf_res1  <= res_r;
          buf_last1 <= sr.last;
        end
      end
    end
  end

endmodule

FILE: sim/testbench.sv
// Testbench for the GELU activation unit: streams signed Q4.12 samples in both function modes.
// Predicts every result with a bit-exact fixed-point model and checks each result transfer.
// Depends on gau_pkg, gau_intf and gelu_activation_unit_top.
`timescale 1ns / 100ps

module testbench;
  import gau_pkg::*;

  localparam int           CLK_HALF    = 6;
  localparam int           LATENCY     = 47;
  localparam int           CYCLE_LIMIT = 400000;

  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] C_ALPHA    = 64'd48012366;
  localparam logic [63:0] C_BETA2    = 64'd1713444046;
  localparam logic [63:0] C_QUICK    = 64'd1827508584;
  localparam logic [63:0] C_LOG2E    = 64'd1549082005;
  localparam logic [63:0] C_LN2      = 64'd744261118;
  localparam logic [63:0] CLAMP_Q16  = 64'd16 << 16;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] result;
    logic                         last;
  } gelu_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  func_mode_t active_mode;

  gelu_result_t pending_results[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  gau_sample_if sample_ch ();
  gau_result_if result_ch ();

  gelu_activation_unit_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Sigmoid of a nonnegative Q.16 argument, returned in Q1.16.
  function automatic logic [63:0] sigmoid_gate_q16(input logic [63:0] z_in);
    logic [63:0] z, t, n, f, u, acc, d, k;
    z = z_in;
    if (z > CLAMP_Q16) z = CLAMP_Q16;
    t = (z * C_LOG2E) >> 16;
    n = t >> 30;
    f = t & (ONE_Q30 - 64'd1);
    u = (f * C_LN2) >> 30;
    acc = ONE_Q30;
    for (k = 64'd6; k >= 64'd1; k = k - 64'd1) begin
      acc = ONE_Q30 - ((u * acc) >> 30) / k;
    end
    if (n > 64'd63) n = 64'd63;
    d = ONE_Q30 + (acc >> n);
    return ((64'd1 << 46) + d / 64'd2) / d;
  endfunction

  function automatic gelu_result_t predict_gelu(input logic signed [DATA_WIDTH-1:0] x,
                                                input logic last, input func_mode_t mode);
    gelu_result_t res;
    longint       xl, r, q;
    logic [63:0]  ax, cube, inner, z, g;
    xl = longint'(x);
    ax = (xl < 0) ? $unsigned(-xl) : $unsigned(xl);
    ax = ax << 4;
    if (ax > CLAMP_Q16) ax = CLAMP_Q16;
    if (mode == MODE_TANH_GELU) begin
      cube  = (((ax * ax) >> 16) * ax) >> 16;
      inner = ax + ((cube * C_ALPHA) >> 30);
      z     = (inner * C_BETA2) >> 30;
    end else begin
      z = (ax * C_QUICK) >> 30;
    end
    g = sigmoid_gate_q16(z);
    if (xl < 0) g = 64'd65536 - g;
    r = xl * longint'(g) + 64'sd32768;
    q = r >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res.result = q[DATA_WIDTH-1:0];
    res.last   = last;
    return res;
  endfunction

  task automatic send_sample(input logic signed [DATA_WIDTH-1:0] x, input logic last);
    @(negedge clk);
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_in <= x;
    sample_ch.last_in   <= last;
    do @(posedge clk); while (!sample_ch.ready);
    pending_results.push_back(predict_gelu(x, last, active_mode));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      sample_ch.valid     <= 1'b0;
      sample_ch.sample_in <= DATA_WIDTH'($urandom);
      sample_ch.last_in   <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_function_mode(input func_mode_t mode);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    active_mode = mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'($urandom_range(0, 1));
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] random_sample();
    logic signed [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 3))
      0: v = DATA_WIDTH'($urandom);
      1: v = DATA_WIDTH'($urandom_range(0, 16383));
      2: v = DATA_WIDTH'($urandom_range(0, 512));
      default: v = DATA_WIDTH'(16'sh7FFF - $urandom_range(0, 64));
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic test_directed(input func_mode_t mode);
    logic signed [DATA_WIDTH-1:0] corner[12];
    int                           i;
    corner = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, 16'sh8000, 16'sd4096,
               -16'sd4096, 16'sd2048, -16'sd2048, 16'sd12288, -16'sd12288, 16'sd20000};
    set_function_mode(mode);
    for (i = 0; i < 12; i++) begin
      send_sample(corner[i], i[0]);
    end
  endtask

  task automatic test_random_stream(input func_mode_t mode, input int n_items);
    int sent, burst, j;
    set_function_mode(mode);
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
      for (j = 0; j < burst && sent < n_items; j++) begin
        send_sample(random_sample(), 1'($urandom_range(0, 1)));
        sent++;
      end
      if (sent == n_items / 2) begin
        drain_results();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 8));
      end
    end
  endtask

  // The receiver cycles through stall styles of random length.
  initial begin
    int style, span, cnt;
    result_ch.ready = 1'b0;
    cnt = 0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        cnt++;
        case (style)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 3) != 0);
          2: result_ch.ready <= ((cnt % 5) < 2);
          default: result_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    gelu_result_t exp_res;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transfer, actual result %0d last %0b", $time,
                 result_ch.result_out, result_ch.last_out);
      end else begin
        exp_res = pending_results.pop_front();
        if (result_ch.result_out !== exp_res.result) begin
          mismatch_count++;
          $display("%0t: result_out mismatch, expected %0d, actual %0d", $time,
                   exp_res.result, result_ch.result_out);
        end
        if (result_ch.last_out !== exp_res.last) begin
          mismatch_count++;
          $display("%0t: last_out mismatch, expected %0b, actual %0b", $time,
                   exp_res.last, result_ch.last_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    sample_ch.valid     = 1'b0;
    sample_ch.sample_in = '0;
    sample_ch.last_in   = 1'b0;
    active_mode         = MODE_TANH_GELU;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed(MODE_TANH_GELU);
    test_directed(MODE_QUICK_GELU);
    test_random_stream(MODE_TANH_GELU, 325);
    test_random_stream(MODE_QUICK_GELU, 325);
    test_random_stream(MODE_QUICK_GELU, 325);
    test_random_stream(MODE_TANH_GELU, 325);
    drain_results();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/gau_pkg.sv
src/gau_intf.sv
src/gau_taylor_step.sv
src/gau_gate_div.sv
src/gelu_activation_unit_top.sv
sim/testbench.sv
